// ===== hw/rtl/bpe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bpe_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_POINTS_DEFAULT  = 8;
  localparam int COORD_WIDTH_DEFAULT = 32;
  localparam int T_FRAC_BITS_DEFAULT = 16;

  // Fixed port widths
  localparam int IDX_WIDTH  = 3;
  localparam int T_IN_WIDTH = 17;
  localparam int DEG_WIDTH  = 3;

  localparam logic [DEG_WIDTH-1:0] DEG_RESET = 3'd3;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } opcode_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bezier_point_evaluator_core.sv =====
// Bezier point evaluator: de Casteljau reduction over control points in a RAM.
// Evaluate items of degree d >= 1 are paced by the single shared multiplier,
// which takes x then y of each step; degree 0 returns point 0 directly.
// One item at a time; the next transfer is possible in the cycle result valid
// rises, later if the previous result still waits on out_stall. Sync
// active-high reset: control points read as zero, degree returns to 3.
`timescale 1ns / 1ps
`default_nettype none

module bezier_point_evaluator_core
  import bpe_pkg::*;
#(
  parameter int MAX_POINTS  = MAX_POINTS_DEFAULT,
  parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT,
  parameter int T_FRAC_BITS = T_FRAC_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  // item input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          opcode,
  input  logic [IDX_WIDTH-1:0]          point_index,
  input  logic signed [COORD_WIDTH-1:0] coord_x,
  input  logic signed [COORD_WIDTH-1:0] coord_y,
  input  logic [T_IN_WIDTH-1:0]         param_t,
  // result output
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] curve_x,
  output logic signed [COORD_WIDTH-1:0] curve_y,
  // degree register write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [DEG_WIDTH-1:0]          cfg_data
);

  localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int RW  = AW + 1;
  localparam int WW  = 2 * COORD_WIDTH;
  localparam int DW  = COORD_WIDTH + 1;        // difference of two coordinates
  localparam int TW  = T_FRAC_BITS + 1;        // t in [0, 1.0]
  localparam int PW  = TW + 1 + DW;            // signed product
  localparam int TCW = (TW > T_IN_WIDTH) ? TW : T_IN_WIDTH;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROW,     // read entry 0 of the current row
    S_PRIME,   // entry 0 arrives as left operand
    S_FETCH,   // right operand arrives, take differences
    S_MULX,
    S_MULY,
    S_WRITE,   // write back interpolated point, chain to next element
    S_DONE
  } state_t;

  state_t state;

  logic [DEG_WIDTH-1:0]   curve_degree;
  logic [MAX_POINTS-1:0]  pt_valid;
  logic                   rd_valid;
  logic                   first_row;
  logic [AW-1:0]          row;
  logic [AW-1:0]          idx;
  logic [TW-1:0]          t_reg;

  logic signed [COORD_WIDTH-1:0] a_x, a_y, b_x, b_y;
  logic signed [COORD_WIDTH-1:0] res_x, res_y;
  logic signed [DW-1:0]          dx, dy;
  logic signed [PW-1:0]          prod;

  // ---------------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------------
  logic in_xfer;
  logic pt_write;
  logic [AW-1:0] pt_addr;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && !in_stall;

  // slots past the store are dropped
  assign pt_write = in_xfer && (opcode == OP_WRITE) &&
                    (32'(point_index) < 32'(MAX_POINTS));
  assign pt_addr  = AW'(point_index);

  // ---------------------------------------------------------------------------
  // Saturated degree and t for a new evaluation
  // ---------------------------------------------------------------------------
  logic [AW-1:0]  deg_sat;
  logic [TCW-1:0] t_ext, t_one, t_sat;

  assign deg_sat = (32'(curve_degree) >= 32'(MAX_POINTS)) ? AW'(MAX_POINTS - 1)
                                                           : AW'(curve_degree);
  assign t_ext = TCW'(param_t);
  assign t_one = TCW'(1) << T_FRAC_BITS;
  assign t_sat = (t_ext > t_one) ? t_one : t_ext;

  // ---------------------------------------------------------------------------
  // Memories: control points (cleared via valid bits) and work row
  // ---------------------------------------------------------------------------
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wk_we;
  logic [WW-1:0] wk_wdata;
  logic [WW-1:0] ctrl_rdata, wk_rdata, rd_word;

  bpe_ram #(
    .WIDTH (WW),
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_ctrl_ram (
    .clk   (clk),
    .we    (pt_write),
    .waddr (pt_addr),
    .wdata ({coord_x, coord_y}),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ctrl_rdata)
  );

  bpe_ram #(
    .WIDTH (WW),
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_work_ram (
    .clk   (clk),
    .we    (wk_we),
    .waddr (idx),
    .wdata (wk_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (wk_rdata)
  );

  // First row reads control points, later rows read the work row.
  // A never-written control point reads as zero.
  always_comb begin
    if (first_row) begin
      rd_word = rd_valid ? ctrl_rdata : '0;
    end else begin
      rd_word = wk_rdata;
    end
  end

  logic signed [COORD_WIDTH-1:0] rd_x, rd_y;
  assign rd_x = rd_word[WW-1:COORD_WIDTH];
  assign rd_y = rd_word[COORD_WIDTH-1:0];

  // ---------------------------------------------------------------------------
  // Datapath: one multiplier, one adder, shared between x and y
  // ---------------------------------------------------------------------------
  logic signed [COORD_WIDTH-1:0] diff_ax, diff_ay, add_a, lerp_res;
  logic signed [DW-1:0]          dx_c, dy_c, d_sel;
  logic signed [PW-1:0]          prod_c, lerp_sum;

  // in S_WRITE the next element's left operand is the current right one
  assign diff_ax = (state == S_WRITE) ? b_x : a_x;
  assign diff_ay = (state == S_WRITE) ? b_y : a_y;
  assign dx_c    = DW'(rd_x) - DW'(diff_ax);
  assign dy_c    = DW'(rd_y) - DW'(diff_ay);

  assign d_sel  = (state == S_MULX) ? dx : dy;
  assign prod_c = $signed({1'b0, t_reg}) * d_sel;

  // floor division by 2^T_FRAC_BITS; result lies between a and b
  assign add_a    = (state == S_MULY) ? a_x : a_y;
  assign lerp_sum = PW'(add_a) + (prod >>> T_FRAC_BITS);
  assign lerp_res = lerp_sum[COORD_WIDTH-1:0];

  // ---------------------------------------------------------------------------
  // Read sequencing: the right operand of the next element is prefetched
  // while the multiplier works, writes trail reads within a row.
  // ---------------------------------------------------------------------------
  logic [RW-1:0] row_ext, idx_p1, idx_p2, idx_p3;

  assign row_ext = {1'b0, row};
  assign idx_p1  = {1'b0, idx} + RW'(1);
  assign idx_p2  = {1'b0, idx} + RW'(2);
  assign idx_p3  = {1'b0, idx} + RW'(3);

  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = '0;
    wk_we    = 1'b0;
    wk_wdata = {res_x, lerp_res};
    case (state)
      S_ROW: begin
        rd_en = 1'b1;
      end
      S_PRIME: begin
        if (row != '0) begin
          rd_en   = 1'b1;
          rd_addr = AW'(1);
        end
      end
      S_FETCH: begin
        if (idx_p2 <= row_ext) begin
          rd_en   = 1'b1;
          rd_addr = idx_p2[AW-1:0];
        end
      end
      S_WRITE: begin
        wk_we = 1'b1;
        if ((idx_p1 < row_ext) && (idx_p3 <= row_ext)) begin
          rd_en   = 1'b1;
          rd_addr = idx_p3[AW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Valid bits, degree register, read-side valid tag
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      pt_valid     <= '0;
      curve_degree <= DEG_RESET;
    end else begin
      if (pt_write) begin
        pt_valid[pt_addr] <= 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        curve_degree <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_valid <= pt_valid[rd_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      first_row <= 1'b0;
    end else begin
      // S_DONE reloads the output register itself
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer && (opcode == OP_EVAL)) begin
            t_reg     <= TW'(t_sat);
            row       <= deg_sat;
            first_row <= 1'b1;
            state     <= S_ROW;
          end
        end
        S_ROW: begin
          idx   <= '0;
          state <= S_PRIME;
        end
        S_PRIME: begin
          a_x <= rd_x;
          a_y <= rd_y;
          if (row == '0) begin
            // degree zero: point 0 itself
            res_x <= rd_x;
            res_y <= rd_y;
            state <= S_DONE;
          end else begin
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          dx    <= dx_c;
          dy    <= dy_c;
          b_x   <= rd_x;
          b_y   <= rd_y;
          state <= S_MULX;
        end
        S_MULX: begin
          prod  <= prod_c;
          state <= S_MULY;
        end
        S_MULY: begin
          prod  <= prod_c;
          res_x <= lerp_res;
          state <= S_WRITE;
        end
        S_WRITE: begin
          a_x <= b_x;
          a_y <= b_y;
          if (idx_p1 < row_ext) begin
            idx   <= idx_p1[AW-1:0];
            dx    <= dx_c;
            dy    <= dy_c;
            b_x   <= rd_x;
            b_y   <= rd_y;
            state <= S_MULX;
          end else if (row == AW'(1)) begin
            res_y <= lerp_res;
            state <= S_DONE;
          end else begin
            row       <= row - AW'(1);
            first_row <= 1'b0;
            state     <= S_ROW;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            curve_x   <= res_x;
            curve_y   <= res_y;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bpe_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bpe_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds until the next read
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
